@@ rtl/sbus_frame_decoder_macros.svh @@
// assertion macros shared by the sbus frame decoder
// depends on a clk and rst signal in the scope of each use
`ifndef SBUS_FRAME_DECODER_MACROS_SVH
`define SBUS_FRAME_DECODER_MACROS_SVH

// same-cycle implication
`define SFD_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFD_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sfd_pkg.sv @@
// types, constants and control structs for the sbus frame decoder
// used by every module of the block, no dependencies
package sfd_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int OUT_CNT_W   = 16;
  localparam int CH_W        = 11;
  localparam int IDX_W       = 4;
  localparam int POS_W       = 5;
  localparam int CHANNELS    = 16;
  localparam int PAYLOAD_BITS = CHANNELS * CH_W;
  localparam int RECIP_SHIFT = 22;
  localparam int PROD_W      = CH_W + RECIP_SHIFT;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_IDLE = 1'b1;

  localparam logic [POS_W-1:0] POS_START    = 5'd0;
  localparam logic [POS_W-1:0] POS_PAY_LAST = 5'd22;
  localparam logic [POS_W-1:0] POS_FLAGS    = 5'd23;
  localparam logic [POS_W-1:0] POS_END      = 5'd24;
  localparam logic [POS_W-1:0] POS_DONE     = 5'd25;

  localparam logic [7:0] START_MARK = 8'h0F;
  localparam logic [7:0] END_MARK   = 8'h00;

  localparam logic [CH_W-1:0] RAW_LO   = 11'd172;
  localparam logic [CH_W-1:0] RAW_HI   = 11'd1811;
  localparam logic [CH_W-1:0] RAW_SPAN = 11'd1639;
  localparam logic [CH_W-1:0] US_LO    = 11'd1000;
  localparam logic [CH_W-1:0] US_HI    = 11'd2000;

  // ceil(1000 * 2^22 / 1639), exact floor for spans up to 1639
  localparam logic [RECIP_SHIFT-1:0] RECIP = 22'd2559063;

  localparam logic [IDX_W-1:0] LAST_CH = 4'd15;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic                 frame_valid;
    logic [IDX_W-1:0]     channel_index;
    logic [CH_W-1:0]      channel_value;
    logic [CH_W-1:0]      pulse_us;
    logic                 ch17_flag;
    logic                 ch18_flag;
    logic                 lost_flag;
    logic                 failsafe_flag;
    logic [OUT_CNT_W-1:0] good_frames;
    logic [OUT_CNT_W-1:0] bad_frames;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic             take_byte;
    logic             take_idle;
    logic             issue;
    logic             issue_good;
    logic             issue_last;
    logic [IDX_W-1:0] chan;
    logic             adv;
  } sfd_cmd_t;

  typedef struct packed {
    logic verdict;
    logic frame_ok;
  } sfd_stat_t;

endpackage

@@ rtl/sfd_ctrl.sv @@
// controller for the sbus frame decoder: request gating, channel sequencing
// and result pipeline valid bits; depends on sfd_pkg
module sfd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_type,
  input  logic                res_stall,
  input  sfd_pkg::sfd_stat_t  stat,
  output sfd_pkg::sfd_cmd_t   cmd,
  output logic                req_stall,
  output logic                res_valid
);

  typedef enum logic [1:0] {IDLE, EMIT, DRAIN} state_t;

  state_t                     state;
  logic [sfd_pkg::IDX_W-1:0]  chan;
  logic                       good;
  logic                       s1_valid;
  logic                       out_valid;
  logic                       adv;
  logic                       in_ok;

  assign adv   = !out_valid || !res_stall;
  assign in_ok = (state == IDLE) && req_valid;

  always_comb begin
    cmd.take_byte  = in_ok && (req_type == sfd_pkg::REQ_BYTE);
    cmd.take_idle  = in_ok && (req_type == sfd_pkg::REQ_IDLE);
    cmd.issue      = (state == EMIT) && adv;
    cmd.issue_good = good;
    cmd.issue_last = !good || (chan == sfd_pkg::LAST_CH);
    cmd.chan       = chan;
    cmd.adv        = adv;
  end

  assign req_stall = (state != IDLE);
  assign res_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      chan      <= '0;
      good      <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= s1_valid;
        s1_valid  <= cmd.issue;
      end
      unique case (state)
        IDLE: begin
          if (cmd.take_byte && stat.verdict) begin
            state <= EMIT;
            chan  <= '0;
            good  <= stat.frame_ok;
          end
        end
        EMIT: begin
          if (adv) begin
            if (cmd.issue_last) begin
              state <= DRAIN;
            end else begin
              chan <= chan + 1'b1;
            end
          end
        end
        DRAIN: begin
          if (!s1_valid && !out_valid) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ rtl/sfd_datapath.sv @@
// datapath for the sbus frame decoder: frame capture, counters, channel
// unpacking and pulse mapping pipeline; depends on sfd_pkg
module sfd_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sfd_pkg::sfd_cmd_t   cmd,
  input  logic [7:0]          rx_byte,
  output sfd_pkg::sfd_stat_t  stat,
  output sfd_pkg::res_t       res
);

  logic [sfd_pkg::POS_W-1:0]        pos;
  logic [7:0]                       start_byte;
  logic [7:0]                       flags;
  logic [sfd_pkg::PAYLOAD_BITS-1:0] payload;
  logic [sfd_pkg::COUNT_WIDTH-1:0]  good_cnt;
  logic [sfd_pkg::COUNT_WIDTH-1:0]  bad_cnt;

  logic                             s1_good;
  logic                             s1_last;
  logic [sfd_pkg::IDX_W-1:0]        s1_idx;
  logic [sfd_pkg::CH_W-1:0]         s1_raw;
  logic [sfd_pkg::CH_W-1:0]         s1_d;

  logic [sfd_pkg::CH_W-1:0]         raw;
  logic [sfd_pkg::CH_W-1:0]         d_next;
  logic [sfd_pkg::PROD_W-1:0]       prod;
  logic [sfd_pkg::CH_W-1:0]         pulse;
  sfd_pkg::res_t                    res_next;

  assign stat.verdict  = (pos == sfd_pkg::POS_END);
  assign stat.frame_ok = (start_byte == sfd_pkg::START_MARK) &&
                         (rx_byte == sfd_pkg::END_MARK);

  // byte capture and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= sfd_pkg::POS_START;
      good_cnt <= '0;
      bad_cnt  <= '0;
    end else if (cmd.take_idle) begin
      pos <= sfd_pkg::POS_START;
    end else if (cmd.take_byte) begin
      if (pos == sfd_pkg::POS_END) begin
        pos <= sfd_pkg::POS_DONE;
        if (stat.frame_ok) begin
          good_cnt <= good_cnt + 1'b1;
        end else begin
          bad_cnt <= bad_cnt + 1'b1;
        end
      end else if (pos < sfd_pkg::POS_END) begin
        pos <= pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      if (pos == sfd_pkg::POS_START) begin
        start_byte <= rx_byte;
      end
      if (pos == sfd_pkg::POS_FLAGS) begin
        flags <= rx_byte;
      end
      if ((pos != sfd_pkg::POS_START) && (pos <= sfd_pkg::POS_PAY_LAST)) begin
        payload <= {rx_byte, payload[sfd_pkg::PAYLOAD_BITS-1:8]};
      end
    end else if (cmd.issue && cmd.issue_good) begin
      payload <= payload >> sfd_pkg::CH_W;
    end
  end

  // stage 1: unpack and clamp
  assign raw = payload[sfd_pkg::CH_W-1:0];

  always_comb begin
    if (raw < sfd_pkg::RAW_LO) begin
      d_next = '0;
    end else if (raw > sfd_pkg::RAW_HI) begin
      d_next = sfd_pkg::RAW_SPAN;
    end else begin
      d_next = raw - sfd_pkg::RAW_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_good <= cmd.issue_good;
      s1_last <= cmd.issue_last;
      s1_idx  <= cmd.chan;
      s1_raw  <= raw;
      s1_d    <= d_next;
    end
  end

  // stage 2: scale to microseconds and build the result
  assign prod  = sfd_pkg::PROD_W'(s1_d) * sfd_pkg::PROD_W'(sfd_pkg::RECIP);
  assign pulse = sfd_pkg::US_LO + prod[sfd_pkg::PROD_W-1:sfd_pkg::RECIP_SHIFT];

  always_comb begin
    res_next             = '0;
    res_next.good_frames = sfd_pkg::OUT_CNT_W'(good_cnt);
    res_next.bad_frames  = sfd_pkg::OUT_CNT_W'(bad_cnt);
    res_next.last        = s1_last;
    if (s1_good) begin
      res_next.frame_valid   = 1'b1;
      res_next.channel_index = s1_idx;
      res_next.channel_value = s1_raw;
      res_next.pulse_us      = pulse;
      res_next.ch17_flag     = flags[0];
      res_next.ch18_flag     = flags[1];
      res_next.lost_flag     = flags[2];
      res_next.failsafe_flag = flags[3];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.adv) begin
      res <= res_next;
    end
  end

endmodule

@@ rtl/sbus_frame_decoder.sv @@
// sbus frame decoder top level: joins controller and datapath
// depends on sfd_pkg, sfd_ctrl, sfd_datapath and the macros header
//
// request channel (req, req_valid, req_stall): one received byte or one
// line idle marker per request. an idle marker restarts the 25-byte frame.
// result channel (res, res_valid, res_stall): one result per channel of a
// good frame. the 25th byte of a frame closes it. after the closing byte
// the sequencer enters EMIT and each result passes stage 1 and the output
// register; a good frame then gives 16 results back to back unless
// res_stall holds them, a bad frame gives one result with frame_valid low.
// req_stall stays high from the closing byte until the last result has
// left the output register and DRAIN has returned to IDLE, as set by the
// 16-step channel sequencer and the two-stage unpack and scale pipeline.
// a result stall holds the output register and freezes the sequencer.
// reset clears the byte position, both frame counters and all valid bits;
// the first frame after reset must start after an idle marker or reset.
`include "sbus_frame_decoder_macros.svh"

module sbus_frame_decoder (
  input  logic           clk,
  input  logic           rst,
  input  sfd_pkg::req_t  req,
  input  logic           req_valid,
  output logic           req_stall,
  output sfd_pkg::res_t  res,
  output logic           res_valid,
  input  logic           res_stall
);

  sfd_pkg::sfd_cmd_t  cmd;
  sfd_pkg::sfd_stat_t stat;

  sfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req.req_type),
    .res_stall (res_stall),
    .stat      (stat),
    .cmd       (cmd),
    .req_stall (req_stall),
    .res_valid (res_valid)
  );

  sfd_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rx_byte (req.rx_byte),
    .stat    (stat),
    .res     (res)
  );

  `SFD_CHECK(a_no_req_while_results, res_valid, req_stall, "request taken with results pending")
  `SFD_CHECK_NEXT(a_burst_contiguous, res_valid && !res_stall && !res.last, res_valid, "gap inside a result burst")
  `SFD_CHECK(a_bad_frame_single, res_valid && !res.frame_valid, res.last && (res.channel_index == '0), "rejected frame result malformed")
  `SFD_CHECK(a_pulse_range, res_valid && res.frame_valid, (res.pulse_us >= sfd_pkg::US_LO) && (res.pulse_us <= sfd_pkg::US_HI), "pulse width out of range")

endmodule
